[rtl/core/ddd_pkg.sv]
package ddd_pkg;

  // One request: two calendar dates.
  typedef struct packed {
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [11:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [11:0] second_year;
  } in_t;

  // One result: signed day count from the first date to the second, and validity flags.
  typedef struct packed {
    logic signed [21:0] day_difference;
    logic               first_valid;
    logic               second_valid;
  } out_t;

  localparam int unsigned Lanes = 2;

  // Reciprocal of 100 scaled by 2^17. It is exact for dividends below 4699, which
  // covers every 12-bit year plus 399.
  localparam logic [10:0] Recip100 = 11'd1311;
  localparam int unsigned RecipShift = 17;

  localparam logic [8:0] DaysPerYear = 9'd365;

  // Days before the first of the month in a common year. Month codes 1 to 12 are used.
  function automatic logic [8:0] month_start_f(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month length in a common year.
  function automatic logic [4:0] month_len_f(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  // Quotient by 100 for values below 4699, done as a multiply by the reciprocal.
  function automatic logic [5:0] div100_f(input logic [12:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'(Recip100);
    return p[RecipShift+5:RecipShift];
  endfunction

endpackage

[rtl/core/date_difference_days_top.sv]
// Signed day count between two Gregorian dates. Each request carries two dates
// (day, month, year); the result gives the number of days from the first date
// to the second, negative when the first date is later, along with a validity
// flag for each date. A date is valid when its month is 1 to 12, its year is
// at most MAX_YEAR and its day lies within that month, February having 29 days
// in leap years (year 0 is a leap year). If either date is invalid the day
// count is zero. The block is a four-stage pipeline: a reciprocal multiply
// that divides the year by 100, the leap rule with the month lookup, the
// multiply of the year by 365, and the final subtract. One request can be
// accepted every cycle while the output is not stalled. Each stage holds its
// data when the stage after it is full and stalled, so bubbles collapse and
// a request can enter while a result waits.
module date_difference_days_top #(
  parameter int MAX_YEAR = 3000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ddd_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ddd_pkg::out_t out_rsp_o
);
  import ddd_pkg::*;

  localparam logic [11:0] MaxYear = 12'(MAX_YEAR);

  // Stage valid bits and per-stage advance enables.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_en, s2_en, s3_en, s4_en;

  assign s4_en = !s4_valid_q || out_ready_i;
  assign s3_en = !s3_valid_q || s4_en;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // Lane 0 holds the first date, lane 1 the second.
  logic [4:0]  in_day   [Lanes];
  logic [3:0]  in_month [Lanes];
  logic [11:0] in_year  [Lanes];

  assign in_day[0]   = in_req_i.first_day;
  assign in_month[0] = in_req_i.first_month;
  assign in_year[0]  = in_req_i.first_year;
  assign in_day[1]   = in_req_i.second_day;
  assign in_month[1] = in_req_i.second_month;
  assign in_year[1]  = in_req_i.second_year;

  // Stage 1 payload.
  logic [4:0]  s1_day_q   [Lanes], s1_day_d   [Lanes];
  logic [3:0]  s1_month_q [Lanes], s1_month_d [Lanes];
  logic [11:0] s1_year_q  [Lanes], s1_year_d  [Lanes];
  logic [5:0]  s1_q0_q    [Lanes], s1_q0_d    [Lanes];
  logic [5:0]  s1_q99_q   [Lanes], s1_q99_d   [Lanes];
  logic [5:0]  s1_q399_q  [Lanes], s1_q399_d  [Lanes];
  logic        s1_ok_q    [Lanes], s1_ok_d    [Lanes];

  // Stage 2 payload.
  logic [11:0] s2_year_q  [Lanes], s2_year_d  [Lanes];
  logic [10:0] s2_leaps_q [Lanes], s2_leaps_d [Lanes];
  logic [8:0]  s2_off_q   [Lanes], s2_off_d   [Lanes];
  logic        s2_ok_q    [Lanes], s2_ok_d    [Lanes];

  // Stage 3 payload.
  logic [20:0] s3_num_q   [Lanes], s3_num_d   [Lanes];
  logic        s3_ok_q    [Lanes], s3_ok_d    [Lanes];

  // Stage 4 is the output register.
  out_t s4_rsp_q, s4_rsp_d;

  always_comb begin
    logic [12:0] hund;
    logic        is_leap;
    logic [4:0]  mlen;
    logic [10:0] by4;
    logic [21:0] n_a;
    logic [21:0] n_b;
    for (int i = 0; i < Lanes; i++) begin
      // Stage 1: quotients by 100 and range checks.
      s1_day_d[i]   = in_day[i];
      s1_month_d[i] = in_month[i];
      s1_year_d[i]  = in_year[i];
      s1_q0_d[i]    = div100_f({1'b0, in_year[i]});
      s1_q99_d[i]   = div100_f(13'(in_year[i]) + 13'd99);
      s1_q399_d[i]  = div100_f(13'(in_year[i]) + 13'd399);
      s1_ok_d[i]    = (in_month[i] >= 4'd1) && (in_month[i] <= 4'd12) &&
                      (in_year[i] <= MaxYear) && (in_day[i] != 5'd0);

      // Stage 2: leap rule, month length check, leap days before the year.
      hund    = 13'(s1_q0_q[i]) * 13'd100;
      is_leap = ((s1_year_q[i][1:0] == 2'b00) && ({1'b0, s1_year_q[i]} != hund)) ||
                (({1'b0, s1_year_q[i]} == hund) && (s1_q0_q[i][1:0] == 2'b00));
      mlen    = month_len_f(s1_month_q[i]);
      if ((s1_month_q[i] == 4'd2) && is_leap) begin
        mlen = 5'd29;
      end
      by4 = 11'((13'(s1_year_q[i]) + 13'd3) >> 2);
      s2_year_d[i]  = s1_year_q[i];
      s2_leaps_d[i] = by4 - 11'(s1_q99_q[i]) + 11'(s1_q399_q[i][5:2]);
      s2_off_d[i]   = month_start_f(s1_month_q[i]) +
                      9'(((s1_month_q[i] > 4'd2) && is_leap) ? 1 : 0) +
                      9'(s1_day_q[i]) - 9'd1;
      s2_ok_d[i]    = s1_ok_q[i] && (s1_day_q[i] <= mlen);

      // Stage 3: day number since 1 January of year 0.
      s3_num_d[i] = 21'(s2_year_q[i]) * 21'(DaysPerYear) + 21'(s2_leaps_q[i]) +
                    21'(s2_off_q[i]);
      s3_ok_d[i]  = s2_ok_q[i];
    end

    // Stage 4: difference, forced to zero when either date is invalid.
    n_a = {1'b0, s3_num_q[0]};
    n_b = {1'b0, s3_num_q[1]};
    s4_rsp_d.first_valid    = s3_ok_q[0];
    s4_rsp_d.second_valid   = s3_ok_q[1];
    s4_rsp_d.day_difference = (s3_ok_q[0] && s3_ok_q[1]) ? signed'(n_b - n_a) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s4_en) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      if (s1_en) begin
        s1_day_q[i]   <= s1_day_d[i];
        s1_month_q[i] <= s1_month_d[i];
        s1_year_q[i]  <= s1_year_d[i];
        s1_q0_q[i]    <= s1_q0_d[i];
        s1_q99_q[i]   <= s1_q99_d[i];
        s1_q399_q[i]  <= s1_q399_d[i];
        s1_ok_q[i]    <= s1_ok_d[i];
      end
      if (s2_en) begin
        s2_year_q[i]  <= s2_year_d[i];
        s2_leaps_q[i] <= s2_leaps_d[i];
        s2_off_q[i]   <= s2_off_d[i];
        s2_ok_q[i]    <= s2_ok_d[i];
      end
      if (s3_en) begin
        s3_num_q[i] <= s3_num_d[i];
        s3_ok_q[i]  <= s3_ok_d[i];
      end
    end
    if (s4_en) begin
      s4_rsp_q <= s4_rsp_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_rsp_o   = s4_rsp_q;

endmodule
